@@ rtl/bfr_pkg.sv @@
// Package for the bitmap font text renderer.
// Request and character codes, register indexes, reset values and the sequencer state type.
// No dependencies.
`default_nettype none

package bfr_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MAC_OP_W = 16;
  localparam int MAC_W = 32;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_PLACE = 2'd1;
  localparam logic [1:0] REQ_DRAW = 2'd2;

  localparam logic [7:0] CODE_CR = 8'd13;
  localparam logic [7:0] CODE_LF = 8'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_GLYPH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_PITCH = 3'd4;

  localparam logic [8:0] RST_GLYPH_COUNT = 9'd256;
  localparam logic [5:0] RST_BYTES_PER_GLYPH = 6'd16;
  localparam logic [5:0] RST_GLYPH_HEIGHT = 6'd16;
  localparam logic [4:0] RST_GLYPH_WIDTH = 5'd8;
  localparam logic [15:0] RST_LINE_PITCH = 16'd4096;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL_ROW,
    ST_MUL_PITCH,
    ST_MUL_COL,
    ST_MUL_BASE,
    ST_SETUP,
    ST_FETCH,
    ST_BLANK
  } seq_state_t;

endpackage

`default_nettype wire

@@ rtl/bfr_mac.sv @@
// Shared multiply-accumulate unit of the renderer: p = a * b + c, registered.
// Depends on bfr_pkg for operand widths.
`default_nettype none

module bfr_mac
  import bfr_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic [MAC_OP_W-1:0] a,
  input  wire logic [MAC_OP_W-1:0] b,
  input  wire logic [MAC_W-1:0]    c,
  output logic      [MAC_W-1:0]    p
);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= MAC_W'(MAC_W'(a) * MAC_W'(b)) + c;
    end
  end

endmodule

`default_nettype wire

@@ rtl/bfr_store.sv @@
// Glyph byte store: one write port, one read port with registered read data.
// No dependencies.
`default_nettype none

module bfr_store #(
  parameter int DEPTH = 8192,
  parameter int AW = 13
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/bitmap_font_text_renderer_unit.sv @@
// Bitmap font text renderer top level: request sequencer, cursor, glyph row fetch and output.
// Depends on bfr_pkg, bfr_mac and bfr_store.
//
// Usage: requests enter on in_valid/in_stall, one item at a time; in_stall is high while a
// request is in progress. A load item writes one glyph byte. A place item, a
// carriage return or a newline updates the cursor in the accepting cycle. A drawn character
// uses the shared multiplier in turn (row, pitch, cell offset, glyph base), then a set-up
// state, and then reads the glyph rows through the single store read port, one byte per
// cycle while the receiver does not stall; a zero width gives blank rows without reads and
// a zero height gives no rows. Each glyph row leaves as one result item on out_valid/out_stall
// from an output register; last_row marks the final row. When the receiver stalls, fetching
// pauses once the last byte of the next row is held in the store read register, with the
// pending row in the output register.
// Configuration is written on cfg_we/cfg_index/cfg_data while no request is in progress.
// Reset returns the registers to their defaults and the cursor to 0,0; store contents are
// undefined until loaded. No clearing pass is run.
`default_nettype none

module bitmap_font_text_renderer_unit
  import bfr_pkg::*;
#(
  parameter int STORE_BYTES = 8192,
  parameter int MAX_HEIGHT = 32,
  parameter int MAX_WIDTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            req_type,
  input  wire logic [12:0]           load_index,
  input  wire logic [7:0]            load_byte,
  input  wire logic [7:0]            start_col,
  input  wire logic [7:0]            start_row,
  input  wire logic [7:0]            char_code,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [31:0]           row_offset,
  output logic      [15:0]           row_bits,
  output logic                       last_row,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(STORE_BYTES);
  localparam int BPL_MAX = (MAX_WIDTH + 7) / 8;
  localparam int KW = (BPL_MAX > 1) ? $clog2(BPL_MAX) : 1;
  localparam int BW = $clog2(BPL_MAX + 1);
  localparam int ACC_W = BPL_MAX * 8;
  localparam int BITS_W = (ACC_W > 16) ? ACC_W : 16;
  localparam logic [AW:0] STORE_LIM = (AW+1)'(STORE_BYTES);

  function automatic logic [AW-1:0] store_mod(input logic [15:0] v);
    logic [24:0] r;
    r = 25'(v);
    for (int k = 7; k >= 0; k--) begin
      if (r >= (25'(STORE_BYTES) << k)) begin
        r = r - (25'(STORE_BYTES) << k);
      end
    end
    return AW'(r);
  endfunction

  seq_state_t state, state_next;

  logic [8:0]  glyph_count;
  logic [5:0]  bytes_per_glyph;
  logic [5:0]  glyph_height;
  logic [4:0]  glyph_width;
  logic [15:0] line_pitch;

  logic [7:0]  cursor_col;
  logic [7:0]  cursor_row;
  logic [12:0] lidx;
  logic [7:0]  lbyte;
  logic [7:0]  code;

  logic [31:0]   row_offs;
  logic [AW-1:0] frow;
  logic [KW-1:0] fk;
  logic [5:0]    fj;
  logic          fetch_done;
  logic          pend;
  logic          pend_first;
  logic          pend_last_byte;
  logic          pend_last_row;
  logic [ACC_W-1:0] acc;

  logic [MAC_OP_W-1:0] mac_a, mac_b;
  logic [MAC_W-1:0]    mac_c, mac_p;
  logic                mac_en;

  logic          store_we;
  logic          issue;
  logic          consume;
  logic          blank_emit;
  logic          emit_row;
  logic [AW-1:0] faddr;
  logic [AW-1:0] frow_step;
  logic [7:0]    rdata;

  logic          in_accept;
  logic          out_free;
  logic [5:0]    h_eff;
  logic [4:0]    w_eff;
  logic [BW-1:0] bpl;
  logic [2:0]    pad;
  logic [7:0]    glyph;
  logic          f_last_byte;
  logic          f_last_row;
  logic [AW:0]   fsum, rsum;
  logic [ACC_W-1:0]  acc_prev, acc_sh;
  logic [BITS_W-1:0] bits_wide;

  assign in_accept = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  assign h_eff = (7'(glyph_height) < 7'(MAX_HEIGHT)) ? glyph_height : 6'(MAX_HEIGHT);
  assign w_eff = (6'(glyph_width) < 6'(MAX_WIDTH)) ? glyph_width : 5'(MAX_WIDTH);
  assign bpl = BW'((6'(w_eff) + 6'd7) >> 3);
  assign pad = 3'((6'(bpl) << 3) - 6'(w_eff));
  assign glyph = ({1'b0, code} < glyph_count) ? code : 8'd0;

  assign f_last_byte = ((BW+1)'(fk) + (BW+1)'(1)) == (BW+1)'(bpl);
  assign f_last_row = (6'(fj + 6'd1)) == h_eff;

  assign fsum = (AW+1)'(frow) + (AW+1)'(fk);
  assign faddr = (fsum >= STORE_LIM) ? AW'(fsum - STORE_LIM) : AW'(fsum);
  assign rsum = (AW+1)'(frow) + (AW+1)'(bpl);
  assign frow_step = (rsum >= STORE_LIM) ? AW'(rsum - STORE_LIM) : AW'(rsum);

  assign acc_prev = pend_first ? '0 : acc;
  assign acc_sh = ACC_W'({acc_prev, rdata});
  assign bits_wide = BITS_W'(acc_sh >> pad);
  assign emit_row = (consume && pend_last_byte) || blank_emit;

  bfr_mac u_mac (
    .clk (clk),
    .en  (mac_en),
    .a   (mac_a),
    .b   (mac_b),
    .c   (mac_c),
    .p   (mac_p)
  );

  bfr_store #(
    .DEPTH (STORE_BYTES),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_mod(16'(lidx))),
    .wdata (lbyte),
    .re    (issue),
    .raddr (faddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          if (req_type == REQ_LOAD) begin
            state_next = ST_LOAD;
          end else if (req_type == REQ_DRAW && char_code != CODE_CR && char_code != CODE_LF) begin
            state_next = ST_MUL_ROW;
          end
        end
      end
      ST_LOAD:      state_next = ST_IDLE;
      ST_MUL_ROW:   state_next = ST_MUL_PITCH;
      ST_MUL_PITCH: state_next = ST_MUL_COL;
      ST_MUL_COL:   state_next = ST_MUL_BASE;
      ST_MUL_BASE:  state_next = ST_SETUP;
      ST_SETUP: begin
        if (h_eff == 6'd0) begin
          state_next = ST_IDLE;
        end else if (bpl == '0) begin
          state_next = ST_BLANK;
        end else begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (consume && pend_last_byte && pend_last_row) begin
          state_next = ST_IDLE;
        end
      end
      ST_BLANK: begin
        if (out_free && f_last_row) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mac_en = 1'b0;
    mac_a = '0;
    mac_b = '0;
    mac_c = '0;
    store_we = 1'b0;
    issue = 1'b0;
    consume = 1'b0;
    blank_emit = 1'b0;
    case (state)
      ST_LOAD: store_we = 1'b1;
      ST_MUL_ROW: begin
        mac_en = 1'b1;
        mac_a = MAC_OP_W'(cursor_row);
        mac_b = MAC_OP_W'(h_eff);
      end
      ST_MUL_PITCH: begin
        mac_en = 1'b1;
        mac_a = mac_p[MAC_OP_W-1:0];
        mac_b = line_pitch;
      end
      ST_MUL_COL: begin
        mac_en = 1'b1;
        mac_a = MAC_OP_W'(cursor_col);
        mac_b = MAC_OP_W'({6'(w_eff) + 6'd1, 2'b00});
        mac_c = mac_p;
      end
      ST_MUL_BASE: begin
        mac_en = 1'b1;
        mac_a = MAC_OP_W'(glyph);
        mac_b = MAC_OP_W'(bytes_per_glyph);
      end
      ST_FETCH: begin
        consume = pend && (!pend_last_byte || out_free);
        issue = (!pend || consume) && !fetch_done;
      end
      ST_BLANK: blank_emit = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      glyph_count <= RST_GLYPH_COUNT;
      bytes_per_glyph <= RST_BYTES_PER_GLYPH;
      glyph_height <= RST_GLYPH_HEIGHT;
      glyph_width <= RST_GLYPH_WIDTH;
      line_pitch <= RST_LINE_PITCH;
      cursor_col <= 8'd0;
      cursor_row <= 8'd0;
      out_valid <= 1'b0;
      pend <= 1'b0;
      fetch_done <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          CFG_GLYPH_COUNT:     glyph_count <= cfg_data[8:0];
          CFG_BYTES_PER_GLYPH: bytes_per_glyph <= cfg_data[5:0];
          CFG_GLYPH_HEIGHT:    glyph_height <= cfg_data[5:0];
          CFG_GLYPH_WIDTH:     glyph_width <= cfg_data[4:0];
          CFG_LINE_PITCH:      line_pitch <= cfg_data;
          default: begin
          end
        endcase
      end

      if (in_accept) begin
        if (req_type == REQ_PLACE) begin
          cursor_col <= start_col;
          cursor_row <= start_row;
        end else if (req_type == REQ_DRAW && char_code == CODE_CR) begin
          cursor_col <= 8'd0;
        end else if (req_type == REQ_DRAW && char_code == CODE_LF) begin
          cursor_col <= 8'd0;
          cursor_row <= cursor_row + 8'd1;
        end
      end else if (state == ST_SETUP && h_eff == 6'd0) begin
        cursor_col <= cursor_col + 8'd1;
      end else if (emit_row && state_next == ST_IDLE) begin
        cursor_col <= cursor_col + 8'd1;
      end

      if (emit_row) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (state == ST_SETUP) begin
        pend <= 1'b0;
        fetch_done <= 1'b0;
      end else if (issue) begin
        pend <= 1'b1;
        if (f_last_byte && f_last_row) begin
          fetch_done <= 1'b1;
        end
      end else if (consume) begin
        pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      lidx <= load_index;
      lbyte <= load_byte;
      code <= char_code;
    end

    if (state == ST_MUL_BASE) begin
      row_offs <= mac_p;
    end else if (emit_row) begin
      row_offs <= row_offs + 32'(line_pitch);
    end

    if (state == ST_SETUP) begin
      frow <= store_mod(mac_p[15:0]);
      fk <= '0;
      fj <= 6'd0;
    end else if (issue) begin
      pend_first <= (fk == '0);
      pend_last_byte <= f_last_byte;
      pend_last_row <= f_last_row;
      if (f_last_byte) begin
        fk <= '0;
        fj <= fj + 6'd1;
        frow <= frow_step;
      end else begin
        fk <= fk + KW'(1);
      end
    end else if (blank_emit) begin
      fj <= fj + 6'd1;
    end

    if (consume) begin
      acc <= acc_sh;
    end

    if (emit_row) begin
      row_offset <= row_offs;
      row_bits <= blank_emit ? 16'd0 : bits_wide[15:0];
      last_row <= blank_emit ? f_last_row : pend_last_row;
    end
  end

endmodule

`default_nettype wire

@@ verif/tb_bitmap_font_text_renderer_unit.sv @@
// Testbench for bitmap_font_text_renderer_unit: queued font loads, cursor moves and characters
// are checked row by row against an in-bench glyph renderer, over several register settings.
// Depends on bfr_pkg and the renderer RTL.
`default_nettype none

module tb_bitmap_font_text_renderer_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import bfr_pkg::*;

  localparam int STORE_BYTES = 8192;
  localparam int MAX_HEIGHT = 32;
  localparam int MAX_WIDTH = 16;
  localparam int SETTLE_CYCLES = 100;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [12:0] load_index;
    logic [7:0]  load_byte;
    logic [7:0]  start_col;
    logic [7:0]  start_row;
    logic [7:0]  char_code;
  } render_req_t;

  typedef struct packed {
    logic [31:0] row_offset;
    logic [15:0] row_bits;
    logic        last_row;
  } glyph_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  render_req_t drive_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] row_offset;
  logic [15:0] row_bits;
  logic last_row;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // renderer copy: font store, cursor, registers
  logic [7:0] font_mem [STORE_BYTES];
  logic [7:0] cur_col = '0;
  logic [7:0] cur_row = '0;
  logic [8:0] glyph_count_r = RST_GLYPH_COUNT;
  logic [5:0] bytes_per_glyph_r = RST_BYTES_PER_GLYPH;
  logic [5:0] glyph_height_r = RST_GLYPH_HEIGHT;
  logic [4:0] glyph_width_r = RST_GLYPH_WIDTH;
  logic [15:0] line_pitch_r = RST_LINE_PITCH;

  // bytes the stimulus has already loaded, so no unwritten byte is ever drawn
  bit byte_loaded [STORE_BYTES];

  render_req_t queued_requests[$];
  glyph_row_t pending_rows[$];

  int sender_idle_pct = 10;
  int receiver_stall_pct = 82;
  int error_count = 0;
  int requests_accepted = 0;
  int chars_drawn = 0;
  int rows_checked = 0;
  int settings_applied = 0;
  int quiet_cycles = 0;

  bitmap_font_text_renderer_unit #(
    .STORE_BYTES(STORE_BYTES),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_WIDTH(MAX_WIDTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(drive_req.kind),
    .load_index(drive_req.load_index),
    .load_byte(drive_req.load_byte),
    .start_col(drive_req.start_col),
    .start_row(drive_req.start_row),
    .char_code(drive_req.char_code),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .row_offset(row_offset),
    .row_bits(row_bits),
    .last_row(last_row),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned used_height();
    return (glyph_height_r < MAX_HEIGHT) ? glyph_height_r : MAX_HEIGHT;
  endfunction

  function automatic int unsigned used_width();
    return (glyph_width_r < MAX_WIDTH) ? glyph_width_r : MAX_WIDTH;
  endfunction

  function automatic render_req_t random_fields();
    logic [63:0] noise;
    noise = {$urandom, $urandom};
    return noise[$bits(render_req_t)-1:0];
  endfunction

  task automatic render_request(input render_req_t r);
    int unsigned h, w, bpl, glyph, base, offs, j, i;
    logic [15:0] bits;
    logic [7:0] font_byte;
    glyph_row_t row_item;
    case (r.kind)
      REQ_LOAD: font_mem[r.load_index] = r.load_byte;
      REQ_PLACE: begin
        cur_col = r.start_col;
        cur_row = r.start_row;
      end
      REQ_DRAW: begin
        if (r.char_code == CODE_CR) begin
          cur_col = '0;
        end else if (r.char_code == CODE_LF) begin
          cur_col = '0;
          cur_row = cur_row + 8'd1;
        end else begin
          h = used_height();
          w = used_width();
          bpl = (w + 7) / 8;
          glyph = (r.char_code < glyph_count_r) ? r.char_code : 0;
          base = glyph * bytes_per_glyph_r;
          offs = cur_row * h * line_pitch_r + cur_col * (w + 1) * 4;
          for (j = 0; j < h; j++) begin
            bits = '0;
            for (i = 0; i < w; i++) begin
              font_byte = font_mem[(base + j * bpl + i / 8) % STORE_BYTES];
              bits = {bits[14:0], font_byte[7 - (i % 8)]};
            end
            row_item.row_offset = offs;
            row_item.row_bits = bits;
            row_item.last_row = (j + 1 == h);
            pending_rows.push_back(row_item);
            offs = offs + line_pitch_r;
          end
          cur_col = cur_col + 8'd1;
          chars_drawn++;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : drive_requests
    render_req_t req_out;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        render_request(drive_req);
        requests_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (queued_requests.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          req_out = queued_requests.pop_front();
          drive_req <= req_out;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_rows
    glyph_row_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_rows.size() == 0) begin
          $error("unexpected glyph row: row_offset %h row_bits %h last_row %b",
                 row_offset, row_bits, last_row);
          error_count++;
        end else begin
          want = pending_rows.pop_front();
          if (row_offset !== want.row_offset) begin
            $error("row_offset: expected %h, got %h", want.row_offset, row_offset);
            error_count++;
          end
          if (row_bits !== want.row_bits) begin
            $error("row_bits: expected %h, got %h", want.row_bits, row_bits);
            error_count++;
          end
          if (last_row !== want.last_row) begin
            $error("last_row: expected %b, got %b", want.last_row, last_row);
            error_count++;
          end
          rows_checked++;
        end
      end
      out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL bitmap_font_text_renderer_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_load(input logic [12:0] idx, input logic [7:0] data);
    render_req_t r;
    r = random_fields();
    r.kind = REQ_LOAD;
    r.load_index = idx;
    r.load_byte = data;
    byte_loaded[idx] = 1'b1;
    queued_requests.push_back(r);
  endtask

  task automatic push_place(input logic [7:0] col, input logic [7:0] row);
    render_req_t r;
    r = random_fields();
    r.kind = REQ_PLACE;
    r.start_col = col;
    r.start_row = row;
    queued_requests.push_back(r);
  endtask

  task automatic push_noise();
    render_req_t r;
    r = random_fields();
    r.kind = REQ_UNUSED;
    queued_requests.push_back(r);
  endtask

  // loads any glyph byte the character will read that has not been loaded yet
  task automatic push_draw(input logic [7:0] code);
    render_req_t r;
    int unsigned glyph, bpl, addr, j, k;
    r = random_fields();
    r.kind = REQ_DRAW;
    r.char_code = code;
    if (code != CODE_CR && code != CODE_LF) begin
      glyph = (code < glyph_count_r) ? code : 0;
      bpl = (used_width() + 7) / 8;
      for (j = 0; j < used_height(); j++) begin
        for (k = 0; k < bpl; k++) begin
          addr = (glyph * bytes_per_glyph_r + j * bpl + k) % STORE_BYTES;
          if (!byte_loaded[addr]) push_load(13'(addr), 8'($urandom));
        end
      end
    end
    queued_requests.push_back(r);
  endtask

  task automatic put_register(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
  endtask

  task automatic write_registers(input logic [8:0] gc, input logic [5:0] bpg,
                                 input logic [5:0] h, input logic [4:0] w,
                                 input logic [15:0] pitch);
    put_register(CFG_GLYPH_COUNT, {7'd0, gc});
    put_register(CFG_BYTES_PER_GLYPH, {10'd0, bpg});
    put_register(CFG_GLYPH_HEIGHT, {10'd0, h});
    put_register(CFG_GLYPH_WIDTH, {11'd0, w});
    put_register(CFG_LINE_PITCH, pitch);
    @(posedge clk);
    cfg_we <= 1'b0;
    glyph_count_r = gc;
    bytes_per_glyph_r = bpg;
    glyph_height_r = h;
    glyph_width_r = w;
    line_pitch_r = pitch;
    settings_applied++;
  endtask

  // zero-height glyphs give no rows, so the pause covers a draw still in flight
  task automatic drain_and_settle();
    while (queued_requests.size() != 0 || in_valid || pending_rows.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(input int n);
    logic [7:0] palette [6];
    int pick, k;
    foreach (palette[p]) palette[p] = 8'($urandom);
    push_draw(8'd255);
    push_draw(8'd0);
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) push_place(8'($urandom), 8'($urandom));
      else if (pick < 16) push_draw(pick[0] ? CODE_CR : CODE_LF);
      else if (pick < 20) push_noise();
      else if (pick < 28) push_load(13'($urandom_range(0, STORE_BYTES - 1)), 8'($urandom));
      else if (pick < 45) push_draw(8'($urandom));
      else push_draw(palette[$urandom_range(0, 5)]);
    end
    drain_and_settle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset settings: extremes of the fields, cursor wrap, unused request kind
    push_load(13'd8191, 8'hFF);
    push_load(13'd0, 8'h00);
    push_load(13'd1, 8'hFF);
    push_draw(8'd0);
    push_draw(8'd255);
    push_noise();
    push_place(8'd255, 8'd255);
    push_draw(8'd65);
    push_draw(8'd66);
    push_draw(CODE_CR);
    push_draw(8'd127);
    push_draw(CODE_LF);
    push_draw(8'd128);
    push_place(8'd0, 8'd0);
    push_draw(8'd1);
    push_place(8'd200, 8'd17);
    push_draw(CODE_LF);
    push_draw(8'd0);
    push_noise();
    drain_and_settle();

    write_registers(9'd0, 6'd0, 6'd1, 5'd1, 16'd0);
    random_phase(30);
    write_registers(9'd511, 6'd63, 6'd63, 5'd31, 16'hFFFF);
    random_phase(20);

    sender_idle_pct = 82;
    receiver_stall_pct = 10;
    write_registers(9'd1, 6'd1, 6'd0, 5'd16, 16'($urandom));
    random_phase(20);
    write_registers(9'($urandom_range(1, 256)), 6'($urandom_range(1, 32)),
                    6'($urandom_range(1, 32)), 5'($urandom_range(0, 16)), 16'($urandom));
    random_phase(35);

    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    write_registers(9'($urandom_range(0, 511)), 6'($urandom_range(0, 63)),
                    6'($urandom_range(0, 63)), 5'($urandom_range(0, 31)), 16'($urandom));
    random_phase(35);
    write_registers(RST_GLYPH_COUNT, RST_BYTES_PER_GLYPH, RST_GLYPH_HEIGHT,
                    RST_GLYPH_WIDTH, RST_LINE_PITCH);
    random_phase(40);

    $display("Covered %0d requests, %0d characters drawn, %0d glyph rows checked",
             requests_accepted, chars_drawn, rows_checked);
    $display("over %0d register settings and three idling patterns", settings_applied + 1);
    if (error_count == 0 && pending_rows.size() == 0) begin
      $display("PASS bitmap_font_text_renderer_unit");
    end else begin
      $display("FAIL bitmap_font_text_renderer_unit");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/bfr_pkg.sv
rtl/bfr_mac.sv
rtl/bfr_store.sv
rtl/bitmap_font_text_renderer_unit.sv
verif/tb_bitmap_font_text_renderer_unit.sv
